// ===== rtl/core/glos_pkg.sv =====
package glos_pkg;

    // Storage size of the solid map
    localparam int MAX_COLUMNS = 64;
    localparam int MAX_ROWS    = 64;
    localparam int MAP_DEPTH   = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W      = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;

    // Pixel coordinates and the quotient bits the divider produces per division
    localparam int COORD_W   = 16;
    localparam int DIV_STEPS = COORD_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Request codes
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_LINE  = 2'd1;
    localparam logic [1:0] OP_POINT = 2'd2;

    // Divider operand selection
    localparam logic [1:0] SEL_SX = 2'd0;
    localparam logic [1:0] SEL_SY = 2'd1;
    localparam logic [1:0] SEL_EX = 2'd2;
    localparam logic [1:0] SEL_EY = 2'd3;

    typedef struct packed {
        logic [1:0]                 op;
        logic [5:0]                 cell_x;
        logic [5:0]                 cell_y;
        logic                       solid;
        logic signed [COORD_W-1:0]  start_x;
        logic signed [COORD_W-1:0]  start_y;
        logic signed [COORD_W-1:0]  end_x;
        logic signed [COORD_W-1:0]  end_y;
    } t_item;

    typedef struct packed {
        logic [6:0] grid_width;
        logic [6:0] grid_height;
        logic [7:0] tile_width;
        logic [7:0] tile_height;
    } t_cfg;

    typedef struct packed {
        logic       clr;
        logic       load;
        logic       wr;
        logic       div_start;
        logic       div_cap;
        logic [1:0] div_sel;
        logic       setup;
        logic       step;
        logic       probe;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
        logic div_done;
        logic walk_last;
        logic hit_now;
    } t_stat;

    function automatic logic [ADDR_W-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                     input logic [COORD_W-1:0] y);
        logic [31:0] lin;
        lin = 32'(y) * 32'(MAX_COLUMNS) + 32'(x);
        return lin[ADDR_W-1:0];
    endfunction

endpackage

// ===== rtl/core/glos_if.sv =====
interface glos_in_if;
    import glos_pkg::*;

    logic                       valid;
    logic                       ready;
    logic [1:0]                 op;
    logic [5:0]                 cell_x;
    logic [5:0]                 cell_y;
    logic                       solid;
    logic signed [COORD_W-1:0]  start_x;
    logic signed [COORD_W-1:0]  start_y;
    logic signed [COORD_W-1:0]  end_x;
    logic signed [COORD_W-1:0]  end_y;

    modport source (output valid, op, cell_x, cell_y, solid, start_x, start_y, end_x, end_y,
                    input ready);
    modport sink   (input valid, op, cell_x, cell_y, solid, start_x, start_y, end_x, end_y,
                    output ready);
endinterface

interface glos_out_if;
    logic valid;
    logic ready;
    logic hit;

    modport source (output valid, hit, input ready);
    modport sink   (input valid, hit, output ready);
endinterface

// ===== rtl/core/grid_line_of_sight_check_top.sv =====
// Line-of-sight checker over a 64 x 64 map of one-bit solid cells. Each input transfer is a
// cell write, a line query or a point query, and each gives exactly one result transfer whose
// hit bit is 1 when a solid in-grid cell was found (always 0 for writes and the unused code).
// Items are handled one at a time. A point query takes two divisions of the pixel coordinates
// by the tile size, one map read, its check and the result register. A line query takes four
// divisions and then walks the cells of the line up to and including the first solid one (all
// of them when none is solid). Four divisions share one radix-2 divider that retires a
// quotient bit per cycle, and the walk visits one cell per cycle on the map's single read
// port. After reset the map is cleared one cell per cycle, all 4096 cells (MAX_COLUMNS x
// MAX_ROWS), during which no item is taken; register writes over the APB port are accepted
// at all times at byte addresses 0, 4, 8, 12 (grid width, grid height, tile width, tile
// height). A tile size of 0 acts as 1.
module grid_line_of_sight_check_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    glos_in_if.sink     i_in,
    glos_out_if.source  o_out,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import glos_pkg::*;

    localparam logic [1:0] REG_GRID_W = 2'd0;
    localparam logic [1:0] REG_GRID_H = 2'd1;
    localparam logic [1:0] REG_TILE_W = 2'd2;
    localparam logic [1:0] REG_TILE_H = 2'd3;

    t_cfg  r_cfg;
    t_item item;
    t_cmd  cmd;
    t_stat stat;
    logic  cfg_wr;

    // Register file: write on the access phase, pready tied high
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_width  <= 7'd64;
            r_cfg.grid_height <= 7'd64;
            r_cfg.tile_width  <= 8'd32;
            r_cfg.tile_height <= 8'd32;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_GRID_W: r_cfg.grid_width  <= pwdata[6:0];
                REG_GRID_H: r_cfg.grid_height <= pwdata[6:0];
                REG_TILE_W: r_cfg.tile_width  <= pwdata[7:0];
                REG_TILE_H: r_cfg.tile_height <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_GRID_W: prdata = {25'd0, r_cfg.grid_width};
            REG_GRID_H: prdata = {25'd0, r_cfg.grid_height};
            REG_TILE_W: prdata = {24'd0, r_cfg.tile_width};
            REG_TILE_H: prdata = {24'd0, r_cfg.tile_height};
            default:    prdata = '0;
        endcase
    end

    // Gather the request payload for the datapath
    assign item.op      = i_in.op;
    assign item.cell_x  = i_in.cell_x;
    assign item.cell_y  = i_in.cell_y;
    assign item.solid   = i_in.solid;
    assign item.start_x = i_in.start_x;
    assign item.start_y = i_in.start_y;
    assign item.end_x   = i_in.end_x;
    assign item.end_y   = i_in.end_y;

    // Sequencer: clearing pass, divisions, walk, and the result register
    glos_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_in_op     (i_in.op),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .o_out_hit   (o_out.hit),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_stat      (stat)
    );

    // Map memory, shared divider and line stepper
    glos_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_item  (item),
        .i_cfg   (r_cfg),
        .i_cmd   (cmd),
        .o_stat  (stat)
    );

endmodule

// ===== rtl/core/glos_div.sv =====
module glos_div (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [glos_pkg::COORD_W-1:0] i_num,
    input  logic [7:0]                        i_den,
    output logic                              o_done,
    output logic signed [glos_pkg::COORD_W-1:0] o_quo
);
    import glos_pkg::*;

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [COORD_W-1:0]   r_mag;
    logic [7:0]           r_rem;
    logic [7:0]           r_den;
    logic                 r_neg;

    logic [8:0]           partial;
    logic                 fits;
    logic [COORD_W-1:0]   num_mag;

    // magnitude of the dividend; the most negative value maps to its unsigned twin
    assign num_mag = i_num[COORD_W-1] ? COORD_W'(-i_num) : COORD_W'(i_num);
    assign partial = {r_rem, r_mag[COORD_W-1]};
    assign fits    = (partial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // one restoring step per cycle, quotient shifts in behind the dividend
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= num_mag;
            r_rem <= '0;
            r_den <= (i_den == 8'd0) ? 8'd1 : i_den;
            r_neg <= i_num[COORD_W-1];
        end else if (r_busy) begin
            r_rem <= fits ? 8'(partial - {1'b0, r_den}) : partial[7:0];
            r_mag <= {r_mag[COORD_W-2:0], fits};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_neg ? $signed(COORD_W'(-r_mag)) : $signed(r_mag);

endmodule

// ===== rtl/core/glos_dp.sv =====
module glos_dp (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  glos_pkg::t_item i_item,
    input  glos_pkg::t_cfg  i_cfg,
    input  glos_pkg::t_cmd  i_cmd,
    output glos_pkg::t_stat o_stat
);
    import glos_pkg::*;

    // clearing pass and read tracking
    logic [ADDR_W-1:0]         r_clr_addr;
    logic                      r_chk;

    // latched request
    logic signed [COORD_W-1:0] r_sx_px;
    logic signed [COORD_W-1:0] r_sy_px;
    logic signed [COORD_W-1:0] r_ex_px;
    logic signed [COORD_W-1:0] r_ey_px;
    logic                      r_pneg;

    // walk state in cell units
    logic signed [COORD_W-1:0] r_x;
    logic signed [COORD_W-1:0] r_y;
    logic signed [COORD_W-1:0] r_ex;
    logic signed [COORD_W-1:0] r_ey;
    logic [COORD_W-1:0]        r_lng;
    logic [COORD_W-1:0]        r_sht;
    logic [COORD_W-1:0]        r_left;
    logic [COORD_W:0]          r_acc;
    logic signed [1:0]         r_diag_x;
    logic signed [1:0]         r_diag_y;
    logic signed [1:0]         r_str_x;
    logic signed [1:0]         r_str_y;

    logic                      r_mem [MAP_DEPTH];
    logic                      r_mem_q;

    logic                      div_done;
    logic signed [COORD_W-1:0] div_quo;
    logic signed [COORD_W-1:0] div_num;
    logic [7:0]                div_den;

    logic [COORD_W-1:0]        used_cols;
    logic [COORD_W-1:0]        used_rows;
    logic                      in_range;
    logic                      wr_ok;
    logic [ADDR_W-1:0]         wr_addr;
    logic [ADDR_W-1:0]         rd_addr;

    logic signed [COORD_W:0]   w;
    logic signed [COORD_W:0]   h;
    logic [COORD_W-1:0]        aw;
    logic [COORD_W-1:0]        ah;
    logic signed [1:0]         sgn_w;
    logic signed [1:0]         sgn_h;
    logic [COORD_W:0]          acc_sum;
    logic                      take_diag;

    always_comb begin
        div_num = r_sx_px;
        div_den = i_cfg.tile_width;
        case (i_cmd.div_sel)
            SEL_SX: begin
                div_num = r_sx_px;
                div_den = i_cfg.tile_width;
            end
            SEL_SY: begin
                div_num = r_sy_px;
                div_den = i_cfg.tile_height;
            end
            SEL_EX: begin
                div_num = r_ex_px;
                div_den = i_cfg.tile_width;
            end
            default: begin
                div_num = r_ey_px;
                div_den = i_cfg.tile_height;
            end
        endcase
    end

    glos_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_num   (div_num),
        .i_den   (div_den),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    assign used_cols = (32'(i_cfg.grid_width) > MAX_COLUMNS) ? COORD_W'(MAX_COLUMNS)
                                                             : COORD_W'(i_cfg.grid_width);
    assign used_rows = (32'(i_cfg.grid_height) > MAX_ROWS) ? COORD_W'(MAX_ROWS)
                                                           : COORD_W'(i_cfg.grid_height);

    // negative or off-grid cells read as free
    assign in_range = !r_x[COORD_W-1] && !r_y[COORD_W-1]
                   && ($unsigned(r_x) < used_cols) && ($unsigned(r_y) < used_rows);

    assign wr_ok   = (32'(i_item.cell_x) < MAX_COLUMNS) && (32'(i_item.cell_y) < MAX_ROWS);
    assign wr_addr = cell_addr(COORD_W'(i_item.cell_x), COORD_W'(i_item.cell_y));
    assign rd_addr = cell_addr(r_x, r_y);

    // line setup: deltas, major axis and step directions
    always_comb begin
        w     = {r_ex[COORD_W-1], r_ex} - {r_x[COORD_W-1], r_x};
        h     = {r_ey[COORD_W-1], r_ey} - {r_y[COORD_W-1], r_y};
        aw    = w[COORD_W] ? COORD_W'(-w) : COORD_W'(w);
        ah    = h[COORD_W] ? COORD_W'(-h) : COORD_W'(h);
        sgn_w = (w == '0) ? 2'sd0 : (w[COORD_W] ? -2'sd1 : 2'sd1);
        sgn_h = (h == '0) ? 2'sd0 : (h[COORD_W] ? -2'sd1 : 2'sd1);
    end

    assign acc_sum   = r_acc + {1'b0, r_sht};
    assign take_diag = (acc_sum >= {1'b0, r_lng});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_addr <= '0;
            r_chk      <= 1'b0;
        end else begin
            if (i_cmd.clr) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
            r_chk <= (i_cmd.step && in_range) || (i_cmd.probe && in_range && !r_pneg);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_sx_px <= i_item.start_x;
            r_sy_px <= i_item.start_y;
            r_ex_px <= i_item.end_x;
            r_ey_px <= i_item.end_y;
            r_pneg  <= i_item.start_x[COORD_W-1] | i_item.start_y[COORD_W-1];
        end

        if (i_cmd.div_cap) begin
            case (i_cmd.div_sel)
                SEL_SX:  r_x  <= div_quo;
                SEL_SY:  r_y  <= div_quo;
                SEL_EX:  r_ex <= div_quo;
                default: r_ey <= div_quo;
            endcase
        end else if (i_cmd.setup) begin
            r_diag_x <= sgn_w;
            r_diag_y <= sgn_h;
            if (aw > ah) begin
                r_lng   <= aw;
                r_sht   <= ah;
                r_left  <= aw;
                r_acc   <= {1'b0, aw >> 1};
                r_str_x <= sgn_w;
                r_str_y <= 2'sd0;
            end else begin
                r_lng   <= ah;
                r_sht   <= aw;
                r_left  <= ah;
                r_acc   <= {1'b0, ah >> 1};
                r_str_x <= 2'sd0;
                r_str_y <= sgn_h;
            end
        end else if (i_cmd.step) begin
            r_left <= r_left - 1'b1;
            if (take_diag) begin
                r_acc <= acc_sum - {1'b0, r_lng};
                r_x   <= r_x + COORD_W'(r_diag_x);
                r_y   <= r_y + COORD_W'(r_diag_y);
            end else begin
                r_acc <= acc_sum;
                r_x   <= r_x + COORD_W'(r_str_x);
                r_y   <= r_y + COORD_W'(r_str_y);
            end
        end
    end

    // solid map: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr) begin
            r_mem[r_clr_addr] <= 1'b0;
        end else if (i_cmd.wr && wr_ok) begin
            r_mem[wr_addr] <= i_item.solid;
        end
        r_mem_q <= r_mem[rd_addr];
    end

    assign o_stat.clr_last  = (r_clr_addr == ADDR_W'(MAP_DEPTH - 1));
    assign o_stat.div_done  = div_done;
    assign o_stat.walk_last = (r_left == '0);
    assign o_stat.hit_now   = r_chk & r_mem_q;

endmodule

// ===== rtl/core/glos_ctrl.sv =====
module glos_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic [1:0]      i_in_op,
    output logic            o_in_ready,
    output logic            o_out_valid,
    output logic            o_out_hit,
    input  logic            i_out_ready,
    output glos_pkg::t_cmd  o_cmd,
    input  glos_pkg::t_stat i_stat
);
    import glos_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_DSTART = 4'd2;
    localparam logic [3:0] S_DWAIT  = 4'd3;
    localparam logic [3:0] S_SETUP  = 4'd4;
    localparam logic [3:0] S_WALK   = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_PROBE  = 4'd7;
    localparam logic [3:0] S_PCHK   = 4'd8;
    localparam logic [3:0] S_FIN    = 4'd9;

    logic [3:0] r_state, n_state;
    logic [1:0] r_sel, n_sel;
    logic       r_line, n_line;
    logic       r_hit, n_hit;
    logic       r_out_valid, n_out_valid;
    logic       r_out_hit, n_out_hit;
    logic       last_sel;

    assign last_sel = r_line ? (r_sel == SEL_EY) : (r_sel == SEL_SY);

    always_comb begin
        n_state     = r_state;
        n_sel       = r_sel;
        n_line      = r_line;
        n_hit       = r_hit;
        n_out_valid = r_out_valid;
        n_out_hit   = r_out_hit;
        o_cmd       = '0;
        o_cmd.div_sel = r_sel;
        o_in_ready  = (r_state == S_IDLE);

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_CLEAR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_hit      = 1'b0;
                    n_sel      = SEL_SX;
                    case (i_in_op)
                        OP_WRITE: begin
                            o_cmd.wr = 1'b1;
                            n_state  = S_FIN;
                        end
                        OP_LINE: begin
                            n_line  = 1'b1;
                            n_state = S_DSTART;
                        end
                        OP_POINT: begin
                            n_line  = 1'b0;
                            n_state = S_DSTART;
                        end
                        default: n_state = S_FIN;
                    endcase
                end
            end
            S_DSTART: begin
                o_cmd.div_start = 1'b1;
                n_state         = S_DWAIT;
            end
            S_DWAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.div_cap = 1'b1;
                    if (last_sel) begin
                        n_state = r_line ? S_SETUP : S_PROBE;
                    end else begin
                        n_sel   = r_sel + 2'd1;
                        n_state = S_DSTART;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_state     = S_WALK;
            end
            S_WALK: begin
                o_cmd.step = 1'b1;
                if (i_stat.hit_now) begin
                    n_hit   = 1'b1;
                    n_state = S_FIN;
                end else if (i_stat.walk_last) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                n_hit   = i_stat.hit_now;
                n_state = S_FIN;
            end
            S_PROBE: begin
                o_cmd.probe = 1'b1;
                n_state     = S_PCHK;
            end
            S_PCHK: begin
                n_hit   = i_stat.hit_now;
                n_state = S_FIN;
            end
            S_FIN: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    n_out_hit   = r_hit;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_sel       <= SEL_SX;
            r_line      <= 1'b0;
            r_hit       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_sel       <= n_sel;
            r_line      <= n_line;
            r_hit       <= n_hit;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_hit <= n_out_hit;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_hit   = r_out_hit;

endmodule

// ===== rtl/core/glos_checker.sv =====
module glos_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready,
    input logic i_out_hit
);
    logic [2:0] r_pend;
    logic       in_xfer;
    logic       out_xfer;

    assign in_xfer  = i_in_valid && i_in_ready;
    assign out_xfer = i_out_valid && i_out_ready;

    // items accepted whose result has not been taken yet
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= '0;
        end else begin
            r_pend <= r_pend + {2'd0, in_xfer} - {2'd0, out_xfer};
        end
    end

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_hit))
        else $error("result dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> !i_in_ready)
        else $error("input taken while an item is still in work");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> r_pend != 3'd0)
        else $error("result shown without an accepted item");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend <= 3'd2)
        else $error("more than one item in work beside a held result");

endmodule

bind grid_line_of_sight_check_top glos_checker u_glos_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_hit   (o_out.hit)
);

// ===== test/glos_regs_pkg.sv =====
package glos_regs_pkg;

    // Register indexes on the APB port; the byte address is the index times four
    localparam logic [1:0] REG_GRID_WIDTH  = 2'd0;
    localparam logic [1:0] REG_GRID_HEIGHT = 2'd1;
    localparam logic [1:0] REG_TILE_WIDTH  = 2'd2;
    localparam logic [1:0] REG_TILE_HEIGHT = 2'd3;

endpackage

// ===== test/glos_hit_checker.sv =====
module glos_hit_checker
    import glos_pkg::*;
    import glos_regs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    glos_in_if          i_in_ch,
    glos_out_if         i_out_ch,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);

    bit         solid_cells [MAP_DEPTH];
    logic [6:0] cfg_grid_w;
    logic [6:0] cfg_grid_h;
    logic [7:0] cfg_tile_w;
    logic [7:0] cfg_tile_h;
    bit         expected_hits [$];
    int         mismatches;

    assign o_fail_count = mismatches;

    function automatic int tile_divisor(input logic [7:0] tile);
        return (tile == 8'd0) ? 1 : int'(tile);
    endfunction

    function automatic int sign_of(input int v);
        return (v < 0) ? -1 : ((v > 0) ? 1 : 0);
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // Off-grid and negative cells count as free
    function automatic bit cell_blocked(input int x, input int y);
        int cols;
        int rows;
        cols = (int'(cfg_grid_w) > MAX_COLUMNS) ? MAX_COLUMNS : int'(cfg_grid_w);
        rows = (int'(cfg_grid_h) > MAX_ROWS) ? MAX_ROWS : int'(cfg_grid_h);
        if (x < 0 || y < 0 || x >= cols || y >= rows)
            return 1'b0;
        return solid_cells[y * MAX_COLUMNS + x];
    endfunction

    function automatic bit line_blocked(input int sx, input int sy, input int ex, input int ey);
        int tw, th, x, y, dx, dy;
        int diag_x, diag_y, step_x, step_y, major, minor, err, i;
        tw = tile_divisor(cfg_tile_w);
        th = tile_divisor(cfg_tile_h);
        x = sx / tw;
        y = sy / th;
        dx = ex / tw - x;
        dy = ey / th - y;
        diag_x = sign_of(dx);
        diag_y = sign_of(dy);
        if (magnitude(dx) > magnitude(dy)) begin
            major = magnitude(dx);
            minor = magnitude(dy);
            step_x = diag_x;
            step_y = 0;
        end else begin
            major = magnitude(dy);
            minor = magnitude(dx);
            step_x = 0;
            step_y = diag_y;
        end
        err = major / 2;
        for (i = 0; i <= major; i++) begin
            if (cell_blocked(x, y))
                return 1'b1;
            err += minor;
            if (err >= major) begin
                err -= major;
                x += diag_x;
                y += diag_y;
            end else begin
                x += step_x;
                y += step_y;
            end
        end
        return 1'b0;
    endfunction

    function automatic bit point_blocked(input int px, input int py);
        if (px < 0 || py < 0)
            return 1'b0;
        return cell_blocked(px / tile_divisor(cfg_tile_w), py / tile_divisor(cfg_tile_h));
    endfunction

    // Apply one request to the shadow map and return the hit it should report
    function automatic bit predict_hit(input logic [1:0] op, input int cx, input int cy,
                                       input bit solid, input int sx, input int sy,
                                       input int ex, input int ey);
        case (op)
            OP_WRITE: begin
                if (cx < MAX_COLUMNS && cy < MAX_ROWS)
                    solid_cells[cy * MAX_COLUMNS + cx] = solid;
                return 1'b0;
            end
            OP_LINE:  return line_blocked(sx, sy, ex, ey);
            OP_POINT: return point_blocked(sx, sy);
            default:  return 1'b0;
        endcase
    endfunction

    always @(posedge i_clk) begin : watch
        bit want;
        bit predicted;
        if (!i_rst_n) begin
            foreach (solid_cells[k])
                solid_cells[k] = 1'b0;
            cfg_grid_w = 7'd64;
            cfg_grid_h = 7'd64;
            cfg_tile_w = 8'd32;
            cfg_tile_h = 8'd32;
            expected_hits.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_GRID_WIDTH:  cfg_grid_w = pwdata[6:0];
                    REG_GRID_HEIGHT: cfg_grid_h = pwdata[6:0];
                    REG_TILE_WIDTH:  cfg_tile_w = pwdata[7:0];
                    REG_TILE_HEIGHT: cfg_tile_h = pwdata[7:0];
                    default: ;
                endcase
            end
            if (i_in_ch.valid && i_in_ch.ready) begin
                predicted = predict_hit(i_in_ch.op, int'(i_in_ch.cell_x),
                                        int'(i_in_ch.cell_y), i_in_ch.solid,
                                        i_in_ch.start_x, i_in_ch.start_y,
                                        i_in_ch.end_x, i_in_ch.end_y);
                expected_hits = {expected_hits, predicted};
            end
            if (i_out_ch.valid && i_out_ch.ready) begin
                if (expected_hits.size() == 0) begin
                    mismatches++;
                    $display("%0t: result transfer with none expected, expected none, got hit=%0b",
                             $time, i_out_ch.hit);
                end else begin
                    want = expected_hits.pop_front();
                    if (i_out_ch.hit !== want) begin
                        mismatches++;
                        $display("%0t: hit mismatch, expected %0b, got %0b",
                                 $time, want, i_out_ch.hit);
                    end
                end
            end
        end
        o_pending <= expected_hits.size();
    end

endmodule

// ===== test/tb_grid_line_of_sight_check_top.sv =====
module tb_grid_line_of_sight_check_top;
    import glos_pkg::*;
    import glos_regs_pkg::*;

    // Code the block must treat as a no-op
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // Generous bound on the whole run, including the map clear after reset
    localparam int CYCLE_LIMIT  = 2_000_000;
    // Quiet time after the last expected result, to catch stray transfers
    localparam int DRAIN_CYCLES = 200;

    // Receiver stall patterns
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_COMB
    } t_rx_pattern;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    glos_in_if  in_ch ();
    glos_out_if out_ch ();

    int fail_count;
    int pending;
    int cycle_count = 0;
    int burst_left;

    // Register values currently programmed; they only shape the stimulus
    int cur_gw;
    int cur_gh;
    int cur_tw;
    int cur_th;

    // Fixed settings covering the extremes: smallest grid and tiles, largest tiles,
    // grid beyond storage with zero tiles, and an uneven mix
    int cfg_table [4][4] = '{
        '{1,   1,   1,   1},
        '{64,  64,  255, 255},
        '{127, 100, 0,   0},
        '{7,   13,  3,   200}
    };
    int phase_len [4] = '{150, 250, 250, 250};

    grid_line_of_sight_check_top u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    glos_hit_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_ch      (in_ch),
        .i_out_ch     (out_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: give up if the run hangs
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("** grid_line_of_sight_check_top: FAILED **");
            $finish;
        end
    end

    // Build one request; fields the op ignores are whatever the caller passes
    function automatic t_item make_item(input logic [1:0] op, input int cx, input int cy,
                                        input int solid_bit, input int sx, input int sy,
                                        input int ex, input int ey);
        t_item it;
        it.op      = op;
        it.cell_x  = 6'(cx);
        it.cell_y  = 6'(cy);
        it.solid   = 1'(solid_bit);
        it.start_x = 16'(sx);
        it.start_y = 16'(sy);
        it.end_x   = 16'(ex);
        it.end_y   = 16'(ey);
        return it;
    endfunction

    // Narrow the working window now and then so writes and queries meet often
    function automatic int focus_span(input int cells);
        return (cells > 12 && $urandom_range(0, 1) == 0) ? 12 : cells;
    endfunction

    // Pixel in or just around the grid, with a random offset inside the tile;
    // negative pixels exercise truncation toward zero
    function automatic logic signed [15:0] near_pixel(input int tile, input int cells);
        int t;
        int c;
        t = (tile == 0) ? 1 : tile;
        c = int'($urandom_range(0, cells + 7)) - 4;
        return 16'(c * t + int'($urandom_range(0, t - 1)));
    endfunction

    function automatic t_item random_request();
        t_item it;
        int    pick;
        int    cols;
        int    rows;
        bit    wide;
        cols = (cur_gw > MAX_COLUMNS) ? MAX_COLUMNS : cur_gw;
        rows = (cur_gh > MAX_ROWS) ? MAX_ROWS : cur_gh;
        // Start from fully random fields so every bit toggles, then shape by op
        it = make_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                       $urandom, $urandom);
        pick = $urandom_range(0, 99);
        if (pick < 35) begin
            it.op = OP_WRITE;
            if ($urandom_range(0, 4) != 0) begin
                it.cell_x = 6'($urandom_range(0, focus_span(cols) - 1));
                it.cell_y = 6'($urandom_range(0, focus_span(rows) - 1));
            end
            it.solid = ($urandom_range(0, 99) < 55);
        end else if (pick < 70) begin
            it.op = OP_LINE;
            // Full-range endpoints only with big tiles, which keeps the walk short
            wide = (cur_tw >= 128) && (cur_th >= 128) && ($urandom_range(0, 3) == 0);
            if (!wide) begin
                it.start_x = near_pixel(cur_tw, focus_span(cols));
                it.start_y = near_pixel(cur_th, focus_span(rows));
                it.end_x   = near_pixel(cur_tw, focus_span(cols));
                it.end_y   = near_pixel(cur_th, focus_span(rows));
            end
        end else if (pick < 96) begin
            it.op = OP_POINT;
            if ($urandom_range(0, 1) == 0) begin
                it.start_x = near_pixel(cur_tw, focus_span(cols));
                it.start_y = near_pixel(cur_th, focus_span(rows));
            end
        end
        return it;
    endfunction

    // Offer one request and hold it until the transfer. Bursts of random length
    // are separated by random gaps with valid dropped.
    task automatic offer(input t_item it);
        int gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 12);
            if (gap > 0) begin
                in_ch.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        in_ch.valid   <= 1'b1;
        in_ch.op      <= it.op;
        in_ch.cell_x  <= it.cell_x;
        in_ch.cell_y  <= it.cell_y;
        in_ch.solid   <= it.solid;
        in_ch.start_x <= it.start_x;
        in_ch.start_y <= it.start_y;
        in_ch.end_x   <= it.end_x;
        in_ch.end_y   <= it.end_y;
        do @(posedge i_clk); while (!in_ch.ready);
        burst_left--;
    endtask

    // Drop valid and wait until every expected result has been seen
    task automatic settle();
        in_ch.valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    // APB write: setup cycle, then access cycle until pready
    task automatic reg_write(input logic [1:0] idx, input int value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        // Bits above the register width are junk the block must drop
        pwdata  <= {24'($urandom_range(0, 32'hFF_FFFF)), 8'(value)};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic apply_config(input int gw, input int gh, input int tw, input int th);
        reg_write(REG_GRID_WIDTH, gw);
        reg_write(REG_GRID_HEIGHT, gh);
        reg_write(REG_TILE_WIDTH, tw);
        reg_write(REG_TILE_HEIGHT, th);
        cur_gw = gw;
        cur_gh = gh;
        cur_tw = tw;
        cur_th = th;
    endtask

    task automatic run_random(input int count);
        repeat (count) offer(random_request());
    endtask

    // Directed requests against the reset settings: 64 x 64 grid, 32-pixel tiles
    task automatic run_directed();
        // Mark the corners and one inner cell
        offer(make_item(OP_WRITE, 0, 0, 1, $urandom, $urandom, $urandom, $urandom));
        offer(make_item(OP_WRITE, 63, 63, 1, $urandom, $urandom, $urandom, $urandom));
        offer(make_item(OP_WRITE, 5, 3, 1, $urandom, $urandom, $urandom, $urandom));
        // Points: both corners, negative coordinates, far off the grid, just past the edge
        offer(make_item(OP_POINT, $urandom, $urandom, $urandom, 0, 0, $urandom, $urandom));
        offer(make_item(OP_POINT, $urandom, $urandom, $urandom, 2047, 2047,
                        $urandom, $urandom));
        offer(make_item(OP_POINT, $urandom, $urandom, $urandom, -1, 5, $urandom, $urandom));
        offer(make_item(OP_POINT, $urandom, $urandom, $urandom, 5, -32768,
                        $urandom, $urandom));
        offer(make_item(OP_POINT, $urandom, $urandom, $urandom, 32767, 32767,
                        $urandom, $urandom));
        offer(make_item(OP_POINT, $urandom, $urandom, $urandom, 2048, 0, $urandom, $urandom));
        // Diagonal starting in negative cells, which must read as free
        offer(make_item(OP_LINE, $urandom, $urandom, $urandom, -100, -100, 100, 100));
        // Vertical walk upward onto the inner cell
        offer(make_item(OP_LINE, $urandom, $urandom, $urandom, 161, 194, 165, 98));
        // Single-cell lines: one free, one reaching the corner through truncation
        offer(make_item(OP_LINE, $urandom, $urandom, $urandom, 400, 400, 400, 400));
        offer(make_item(OP_LINE, $urandom, $urandom, $urandom, -31, -31, -31, -31));
        // Unused code changes nothing
        offer(make_item(OP_UNUSED, $urandom, $urandom, $urandom, $urandom, $urandom,
                        $urandom, $urandom));
        // Clear a corner again and confirm
        offer(make_item(OP_WRITE, 0, 0, 0, $urandom, $urandom, $urandom, $urandom));
        offer(make_item(OP_POINT, $urandom, $urandom, $urandom, 0, 0, $urandom, $urandom));
        // Full-range diagonals: one crosses the far corner, the other never enters the grid
        offer(make_item(OP_LINE, $urandom, $urandom, $urandom, -32768, -32768, 32767, 32767));
        offer(make_item(OP_LINE, $urandom, $urandom, $urandom, 32767, -32768, -32768, 32767));
        // Row sweep, anti-diagonal inside the grid, shallow x-major slope
        offer(make_item(OP_LINE, $urandom, $urandom, $urandom, 0, 96, 2047, 127));
        offer(make_item(OP_LINE, $urandom, $urandom, $urandom, 2047, 0, 0, 2047));
        offer(make_item(OP_LINE, $urandom, $urandom, $urandom, 0, 0, 2047, 700));
        offer(make_item(OP_WRITE, 63, 0, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                        32'hFFFF_FFFF));
    endtask

    // Receiver pacing: a stall pattern drawn anew whenever the last one runs out, plus
    // an occasional long hold-off so the block backs up and stalls its input
    initial begin : rx_pacing
        t_rx_pattern pattern;
        int          pattern_left;
        int          hold_left;
        int          next_hold;
        pattern      = RX_OPEN;
        pattern_left = 0;
        hold_left    = 0;
        // First hold-off lands after the map clear that follows reset
        next_hold    = $urandom_range(5000, 9000);
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!i_rst_n) begin
                out_ch.ready <= 1'b0;
            end else if (hold_left > 0) begin
                out_ch.ready <= 1'b0;
                hold_left--;
            end else if (next_hold == 0) begin
                hold_left    = $urandom_range(300, 600);
                next_hold    = $urandom_range(4000, 20000);
                out_ch.ready <= 1'b0;
            end else begin
                next_hold--;
                if (pattern_left == 0) begin
                    pattern      = t_rx_pattern'($urandom_range(0, 3));
                    pattern_left = $urandom_range(40, 400);
                end else begin
                    pattern_left--;
                end
                case (pattern)
                    RX_OPEN:   out_ch.ready <= 1'b1;
                    RX_COIN:   out_ch.ready <= 1'($urandom);
                    RX_SPARSE: out_ch.ready <= ($urandom_range(0, 3) == 0);
                    default:   out_ch.ready <= (pattern_left % 3 != 0);
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial begin : stimulus
        int phase;
        in_ch.valid   <= 1'b0;
        in_ch.op      <= OP_WRITE;
        in_ch.cell_x  <= '0;
        in_ch.cell_y  <= '0;
        in_ch.solid   <= 1'b0;
        in_ch.start_x <= '0;
        in_ch.start_y <= '0;
        in_ch.end_x   <= '0;
        in_ch.end_y   <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        burst_left    = 0;
        cur_gw        = 64;
        cur_gh        = 64;
        cur_tw        = 32;
        cur_th        = 32;

        // Hold reset from time zero, then release for good
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset settings first; the block only starts taking requests once its
        // map clear is done, which the handshake absorbs
        run_directed();
        run_random(180);

        // Reprogram only with nothing in flight: fixed extremes, then random settings
        for (phase = 0; phase < 8; phase++) begin
            settle();
            if (phase < 4) begin
                apply_config(cfg_table[phase][0], cfg_table[phase][1],
                             cfg_table[phase][2], cfg_table[phase][3]);
                run_random(phase_len[phase]);
            end else begin
                apply_config($urandom_range(1, 127), $urandom_range(1, 127),
                             $urandom_range(0, 255), $urandom_range(0, 255));
                run_random(200);
            end
        end

        // Wait out the last results, then keep watching for strays
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0)
            $display("** grid_line_of_sight_check_top: PASSED **");
        else
            $display("** grid_line_of_sight_check_top: FAILED **");
        $finish;
    end

endmodule
